// File: design/srq_pkg.sv
// Shared types and constants for the sequenced retransmit queue.
`timescale 1ns / 1ps
`default_nettype none
package srq_pkg;

  // Ring depth; must be a power of two so the slot is the low sequence bits.
  localparam int DEPTH  = 1024;
  localparam int SLOT_W = $clog2(DEPTH);

  // Field widths
  localparam int SEQ_W  = 32;
  localparam int OFF_W  = 20;
  localparam int LEN_W  = 16;
  localparam int PEND_W = 11;
  localparam int CFG_W  = 20;

  // Configuration register indexes
  localparam logic CFG_MAX_PENDING = 1'b0;
  localparam logic CFG_BUFFER_SIZE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [PEND_W-1:0] MAX_PENDING_RST = PEND_W'(1000);
  localparam logic [OFF_W-1:0]  BUFFER_SIZE_RST = OFF_W'(262144);

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_READ_HEAD = 2'd1,
    OP_MARK_SENT = 2'd2,
    OP_FETCH     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [LEN_W-1:0] msg_len;
    logic [SEQ_W-1:0] seq;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SEQ_W-1:0]  seq_out;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic [PEND_W-1:0] pending;
  } res_t;

  // One stored message descriptor
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } desc_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic              idle;
    logic              exec;
    logic              clearing;
    logic [SLOT_W-1:0] clr_idx;
  } ctrl_t;

endpackage
`default_nettype wire

// File: design/srq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module srq_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/srq_ctrl.sv
// Sequencer: post-reset clearing sweep, then accept / execute per request.
`timescale 1ns / 1ps
`default_nettype none
module srq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output srq_pkg::ctrl_t     ctrl
);
  import srq_pkg::*;

  state_e            state, state_next;
  logic [SLOT_W-1:0] clr_idx;
  logic              clr_last;

  assign clr_last = (clr_idx == SLOT_W'(DEPTH - 1));

  // State register and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SLOT_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl          = '0;
    ctrl.clr_idx  = clr_idx;
    unique case (state)
      ST_CLEAR: ctrl.clearing = 1'b1;
      ST_IDLE:  ctrl.idle     = 1'b1;
      ST_EXEC:  ctrl.exec     = 1'b1;
      default:  ctrl.clearing = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/sequenced_retransmit_queue_core.sv
// Top level of the sequenced retransmit queue: descriptor ring and request datapath.
//
// Usage
//   Request channel: a request (add, read head, mark head sent, fetch by sequence)
//   is taken at a rising edge with start high and busy low.
//   Result channel: done is high for exactly one cycle with the result alongside;
//   the receiver must take it then, there is no back-pressure.
//   Configuration: cfg_we with cfg_index 0 (max_pending) or 1 (buffer_size) and
//   cfg_data writes a register at the edge; write only while no request is open.
// Timing
//   A request is taken, then executed in the next cycle (descriptor memory read
//   data arrives, the entry is written back), and its result is registered and
//   shows on done in the cycle after. busy is high during the execute cycle, so
//   a new request is not taken until the previous one has executed. The next
//   request may be taken in the same cycle as the previous result is shown.
// Reset
//   rst is synchronous. Afterwards the block sweeps the descriptor memories to
//   zero, one entry per cycle, through all 1024 entries with busy high; configuration
//   writes are still taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module sequenced_retransmit_queue_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire srq_pkg::req_t                  request,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [srq_pkg::CFG_W-1:0]      cfg_data,
  output logic                                done,
  output srq_pkg::res_t                       result
);
  import srq_pkg::*;

  ctrl_t             ctrl;
  req_t              req_q;
  logic [PEND_W-1:0] max_pending;
  logic [OFF_W-1:0]  buffer_size;
  logic [SEQ_W-1:0]  write_seq, write_seq_next;
  logic [SEQ_W-1:0]  head_seq, head_seq_next;
  logic [OFF_W-1:0]  write_pos, write_pos_next;
  res_t              res_next;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  desc_t             mem_wdata;
  logic [SLOT_W-1:0] rd_addr;
  desc_t             rd_desc;
  logic [SEQ_W-1:0]  head_slot_seq;

  logic [SEQ_W-1:0]  pend;
  logic [OFF_W:0]    npos;

  // Head moves to s + 1 when head <= s < write
  function automatic logic [SEQ_W-1:0] adv_head(input logic [SEQ_W-1:0] s,
                                                input logic [SEQ_W-1:0] hd,
                                                input logic [SEQ_W-1:0] ws);
    logic [SEQ_W-1:0] r;
    r = hd;
    if (s >= hd && s < ws) r = s + SEQ_W'(1);
    return r;
  endfunction

  srq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl)
  );

  assign busy = !ctrl.idle;

  // Read slot chosen at request time: fetch slot or head slot
  assign rd_addr = (request.operation == OP_FETCH) ? request.seq[SLOT_W-1:0]
                                                   : head_seq[SLOT_W-1:0];

  // Full descriptor ring
  srq_ram #(.WIDTH($bits(desc_t)), .ADDR_W(SLOT_W)) u_desc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_desc)
  );

  // Sequence-only mirror, always read at the head slot
  srq_ram #(.WIDTH(SEQ_W), .ADDR_W(SLOT_W)) u_seq_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata.seq),
    .raddr (head_seq[SLOT_W-1:0]),
    .rdata (head_slot_seq)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pending <= MAX_PENDING_RST;
      buffer_size <= BUFFER_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PENDING: max_pending <= cfg_data[PEND_W-1:0];
        CFG_BUFFER_SIZE: buffer_size <= cfg_data[OFF_W-1:0];
        default:         max_pending <= max_pending;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (ctrl.idle && start) begin
      req_q <= request;
    end
  end

  // Execute: decide result, pointer updates and the write-back
  always_comb begin
    pend           = write_seq - head_seq;
    npos           = {1'b0, write_pos} + (OFF_W + 1)'(req_q.msg_len);
    write_seq_next = write_seq;
    head_seq_next  = head_seq;
    write_pos_next = write_pos;
    res_next       = '0;
    mem_we         = 1'b0;
    mem_waddr      = write_seq[SLOT_W-1:0];
    mem_wdata      = '{seq: write_seq, offset: write_pos, length: req_q.msg_len};

    unique case (req_q.operation)
      OP_ADD: begin
        if (pend < {{(SEQ_W - PEND_W){1'b0}}, max_pending}) begin
          mem_we           = ctrl.exec;
          write_pos_next   = (npos > {1'b0, buffer_size}) ? '0 : npos[OFF_W-1:0];
          write_seq_next   = write_seq + SEQ_W'(1);
          res_next.ok      = 1'b1;
          res_next.seq_out = write_seq;
          res_next.offset  = write_pos;
          res_next.length  = req_q.msg_len;
        end
      end
      OP_READ_HEAD: begin
        if (pend != '0) begin
          res_next.ok      = 1'b1;
          res_next.seq_out = rd_desc.seq;
          res_next.offset  = rd_desc.offset;
          res_next.length  = rd_desc.length;
        end
      end
      OP_MARK_SENT: begin
        if (pend != '0) begin
          head_seq_next    = head_seq + SEQ_W'(1);
          res_next.ok      = 1'b1;
          res_next.seq_out = head_seq;
        end
      end
      OP_FETCH: begin
        if (req_q.seq == '0) begin
          head_seq_next = head_seq;
        end else if (rd_desc.seq == req_q.seq) begin
          head_seq_next    = adv_head(req_q.seq, head_seq, write_seq);
          res_next.ok      = 1'b1;
          res_next.seq_out = rd_desc.seq;
          res_next.offset  = rd_desc.offset;
          res_next.length  = rd_desc.length;
        end else if (rd_desc.seq < req_q.seq) begin
          // stored entry is older: step back one only if the head slot is near
          if (head_slot_seq != '0 &&
              ({1'b0, head_slot_seq} + (SEQ_W + 1)'(DEPTH)) >= {1'b0, req_q.seq}) begin
            head_seq_next = adv_head(req_q.seq - SEQ_W'(1), head_seq, write_seq);
          end
        end else begin
          head_seq_next = adv_head(req_q.seq, head_seq, write_seq);
        end
      end
      default: res_next = '0;
    endcase

    res_next.pending = PEND_W'(write_seq_next - head_seq_next);

    // Clearing sweep overrides the write port
    if (ctrl.clearing) begin
      mem_we    = 1'b1;
      mem_waddr = ctrl.clr_idx;
      mem_wdata = '0;
    end
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_seq <= SEQ_W'(1);
      head_seq  <= SEQ_W'(1);
      write_pos <= '0;
    end else if (ctrl.exec) begin
      write_seq <= write_seq_next;
      head_seq  <= head_seq_next;
      write_pos <= write_pos_next;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: design/srq_checker.sv
// Port-level checker for the sequenced retransmit queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module srq_checker (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire srq_pkg::res_t result
);
  import srq_pkg::*;

  // Every result follows a taken request through the execute state and the done register
  a_done_after_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a request two cycles earlier");

  // A taken request holds off the next one for its execute cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after taking a request");

  // Results never come back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // A refused or missed request carries an empty descriptor
  a_fail_is_empty: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |->
      (result.seq_out == '0 && result.offset == '0 && result.length == '0))
    else $error("failed request carries descriptor data");

endmodule

bind sequenced_retransmit_queue_core srq_checker u_srq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

// File: tb/sv/srq_result_checker.sv
// Checker for the sequenced retransmit queue: predicts each result and compares it.
`timescale 1ns / 1ps
module srq_result_checker
  import srq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  req_t                  request,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             done,
  input  res_t                  result,
  output int                    error_count,
  output int                    results_owed
);

  // Own copy of the descriptor ring, pointers and registers
  logic [SEQ_W-1:0]  ring_seq [DEPTH];
  logic [OFF_W-1:0]  ring_off [DEPTH];
  logic [LEN_W-1:0]  ring_len [DEPTH];
  logic [SEQ_W-1:0]  wr_seq;
  logic [SEQ_W-1:0]  hd_seq;
  logic [OFF_W-1:0]  wr_pos;
  logic [PEND_W-1:0] max_pend;
  logic [OFF_W-1:0]  wrap_limit;

  res_t awaited_results [$];
  int   errors;

  // Head only moves forward, and never past the write pointer
  function automatic void move_head(logic [SEQ_W-1:0] s);
    if (s >= hd_seq && s < wr_seq) begin
      hd_seq = s + SEQ_W'(1);
    end
  endfunction

  // Applies one request to the ring and returns the result it should give
  function automatic res_t queue_outcome(req_t r);
    res_t              res;
    logic [SEQ_W-1:0]  pend;
    logic [SEQ_W-1:0]  stored;
    logic [SEQ_W-1:0]  head_stored;
    logic [SLOT_W-1:0] idx;
    logic [OFF_W:0]    npos;
    res  = '0;
    pend = wr_seq - hd_seq;
    case (r.operation)
      OP_ADD: begin
        if (pend < {{(SEQ_W-PEND_W){1'b0}}, max_pend}) begin
          idx           = wr_seq[SLOT_W-1:0];
          ring_seq[idx] = wr_seq;
          ring_off[idx] = wr_pos;
          ring_len[idx] = r.msg_len;
          res.ok        = 1'b1;
          res.seq_out   = wr_seq;
          res.offset    = wr_pos;
          res.length    = r.msg_len;
          // advanced offset is kept one bit wider so the wrap test sees the carry
          npos   = {1'b0, wr_pos} + {{(OFF_W+1-LEN_W){1'b0}}, r.msg_len};
          wr_pos = (npos > {1'b0, wrap_limit}) ? '0 : npos[OFF_W-1:0];
          wr_seq = wr_seq + SEQ_W'(1);
        end
      end
      OP_READ_HEAD: begin
        if (pend != '0) begin
          idx         = hd_seq[SLOT_W-1:0];
          res.ok      = 1'b1;
          res.seq_out = ring_seq[idx];
          res.offset  = ring_off[idx];
          res.length  = ring_len[idx];
        end
      end
      OP_MARK_SENT: begin
        if (pend != '0) begin
          res.ok      = 1'b1;
          res.seq_out = hd_seq;
          hd_seq      = hd_seq + SEQ_W'(1);
        end
      end
      OP_FETCH: begin
        idx    = r.seq[SLOT_W-1:0];
        stored = ring_seq[idx];
        // sequence zero never matches and leaves the head alone
        if (r.seq != '0) begin
          if (stored == r.seq) begin
            move_head(r.seq);
            res.ok      = 1'b1;
            res.seq_out = stored;
            res.offset  = ring_off[idx];
            res.length  = ring_len[idx];
          end else if (stored < r.seq) begin
            // slot is stale: step back one, if the head slot is live and close enough
            head_stored = ring_seq[hd_seq[SLOT_W-1:0]];
            if (head_stored != '0 &&
                {1'b0, head_stored} + (SEQ_W+1)'(DEPTH) >= {1'b0, r.seq}) begin
              move_head(r.seq - SEQ_W'(1));
            end
          end else begin
            move_head(r.seq);
          end
        end
      end
    endcase
    res.pending = PEND_W'(wr_seq - hd_seq);
    return res;
  endfunction

  function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Track configuration, requests and results on every edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring_seq[i] = '0;
        ring_off[i] = '0;
        ring_len[i] = '0;
      end
      wr_seq     = 1;
      hd_seq     = 1;
      wr_pos     = '0;
      max_pend   = MAX_PENDING_RST;
      wrap_limit = BUFFER_SIZE_RST;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_PENDING) begin
          max_pend = cfg_data[PEND_W-1:0];
        end else begin
          wrap_limit = cfg_data[OFF_W-1:0];
        end
      end
      // result first: a new request's result cannot come in the same cycle
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request waiting: seq_out %0d", result.seq_out);
          errors++;
        end else begin
          check_field("ok", awaited_results[0].ok, result.ok);
          check_field("seq_out", awaited_results[0].seq_out, result.seq_out);
          check_field("offset", awaited_results[0].offset, result.offset);
          check_field("length", awaited_results[0].length, result.length);
          check_field("pending", awaited_results[0].pending, result.pending);
          void'(awaited_results.pop_front());
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(queue_outcome(request));
      end
    end
    error_count  <= errors;
    results_owed <= awaited_results.size();
  end

  initial begin
    errors = 0;
  end

endmodule

// File: tb/sv/sequenced_retransmit_queue_core_test.sv
// Top of the retransmit queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module sequenced_retransmit_queue_core_test;
  import srq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int IDLE_PERCENT  = 8;
  localparam int QUIET_PHASE   = 5;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start;
  logic             busy;
  req_t             request;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             done;
  res_t             result;
  int               error_count;
  int               results_owed;
  logic [SEQ_W-1:0] recent_seq;
  bit               quiet;

  sequenced_retransmit_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  srq_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .result       (result),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Last sequence seen in a good result steers fetches towards the live window
  always @(posedge clk) begin
    if (rst) begin
      recent_seq <= 1;
    end else if (done && result.ok) begin
      recent_seq <= result.seq_out;
    end
  end

  function automatic req_t make_request(op_e op, logic [LEN_W-1:0] len,
                                        logic [SEQ_W-1:0] sq);
    req_t r;
    r.operation = op;
    r.msg_len   = len;
    r.seq       = sq;
    return r;
  endfunction

  function automatic req_t random_request(int add_pct);
    req_t r;
    int   pick;
    r.msg_len = ($urandom_range(9) < 7) ? LEN_W'($urandom) : LEN_W'($urandom_range(64));
    r.seq     = $urandom;
    if ($urandom_range(99) < add_pct) begin
      r.operation = OP_ADD;
    end else begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        r.operation = OP_READ_HEAD;
      end else if (pick < 5) begin
        r.operation = OP_MARK_SENT;
      end else begin
        r.operation = OP_FETCH;
        pick = $urandom_range(19);
        case (pick)
          0: r.seq = '0;
          1: r.seq = $urandom;
          2: r.seq = recent_seq + SEQ_W'(DEPTH) + SEQ_W'($urandom_range(3));
          3: r.seq = recent_seq - SEQ_W'(DEPTH) + SEQ_W'($urandom_range(3));
          4: r.seq = recent_seq - SEQ_W'($urandom_range(2 * DEPTH));
          default: begin
            r.seq = recent_seq + SEQ_W'($urandom_range(4)) - SEQ_W'($urandom_range(40));
          end
        endcase
      end
    end
    return r;
  endfunction

  // Holds start and the request until the block takes it; start stays high
  task automatic send_request(input req_t r);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random idle gap in front of a request, unless in the quiet stretch
  task automatic send_paced(input req_t r);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send_request(r);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_config(input int mp, input int bs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_PENDING;
    cfg_data  <= CFG_W'(mp);
    @(posedge clk);
    cfg_index <= CFG_BUFFER_SIZE;
    cfg_data  <= CFG_W'(bs);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sequenced_retransmit_queue_core: mismatch");
    $finish;
  end

  initial begin
    req_t default_set [$];
    req_t tight_set [$];
    int   mp;
    int   bs;
    int   add_pct;
    start     = 1'b0;
    request   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAX_PENDING;
    cfg_data  = '0;
    quiet     = 1'b0;

    // Reset-value registers: empty queue, both length extremes, wrap, hits and misses
    default_set.push_back(make_request(OP_READ_HEAD, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_MARK_SENT, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd5));
    default_set.push_back(make_request(OP_ADD, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_ADD, 16'hFFFF, 32'd0));
    default_set.push_back(make_request(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF));
    default_set.push_back(make_request(OP_READ_HEAD, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd2));
    default_set.push_back(make_request(OP_FETCH, 16'hFFFF, 32'hFFFF_FFFF));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd1));
    default_set.push_back(make_request(OP_MARK_SENT, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_READ_HEAD, 16'd0, 32'd0));
    default_set.push_back(make_request(OP_ADD, 16'hFFFF, 32'd0));
    default_set.push_back(make_request(OP_ADD, 16'hFFFF, 32'd0));
    default_set.push_back(make_request(OP_ADD, 16'hFFFF, 32'd0));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd1025));
    default_set.push_back(make_request(OP_FETCH, 16'd0, 32'd6));

    // One pending allowed, zero-size buffer: refusal and offset held at zero
    tight_set.push_back(make_request(OP_ADD, 16'd7, 32'd0));
    tight_set.push_back(make_request(OP_ADD, 16'd1, 32'd0));
    tight_set.push_back(make_request(OP_READ_HEAD, 16'd0, 32'd0));
    tight_set.push_back(make_request(OP_MARK_SENT, 16'd0, 32'd0));
    tight_set.push_back(make_request(OP_ADD, 16'd0, 32'd0));
    tight_set.push_back(make_request(OP_FETCH, 16'd0, 32'd8));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (default_set[i]) send_paced(default_set[i]);
    drain_results();
    write_config(1, 0);
    foreach (tight_set[i]) send_paced(tight_set[i]);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin mp = 1024; bs = 1048575; add_pct = 85; end
        1: begin mp = 1024; bs = 0;       add_pct = 50; end
        2: begin mp = 1;    bs = 1048575; add_pct = 50; end
        3: begin mp = 3;    bs = 70000;   add_pct = 50; end
        4: begin
          mp = $urandom_range(1, 1024);
          bs = $urandom_range(1048575);
          add_pct = 85;
        end
        5: begin mp = 1000; bs = 262144;  add_pct = 50; end
        6: begin mp = 1024; bs = $urandom_range(1048575); add_pct = 85; end
        default: begin
          mp = $urandom_range(1, 1024);
          bs = $urandom_range(1048575);
          add_pct = 50;
        end
      endcase
      write_config(mp, bs);
      quiet = (p == QUIET_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_paced(random_request(add_pct));
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("sequenced_retransmit_queue_core: match");
    end else begin
      $display("sequenced_retransmit_queue_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/srq_pkg.sv
design/srq_ram.sv
design/srq_ctrl.sv
design/sequenced_retransmit_queue_core.sv
design/srq_checker.sv
tb/sv/srq_result_checker.sv
tb/sv/sequenced_retransmit_queue_core_test.sv
